[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[design/fmatt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmatt_pkg
// Shared widths, function codes, rule record and prefix mask helper.
// ----------------------------------------------------------------------------
package fmatt_pkg;

   localparam int IP_W     = 32;
   localparam int PORT_W   = 16;
   localparam int PLEN_W   = 6;
   localparam int FUNC_W   = 2;
   localparam int RULE_SLOTS_DEF = 64;

   localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

   localparam logic [PLEN_W-1:0] PLEN_HOST = 6'd32;

   typedef struct packed {
      logic [IP_W-1:0]   match_ip;
      logic [PORT_W-1:0] match_port;
      logic [IP_W-1:0]   repl_ip;
      logic [PORT_W-1:0] repl_port;
      logic [IP_W-1:0]   net_base;
      logic [PLEN_W-1:0] prefix_len;
   } rule_type;

   // top len bits set; zero length gives an empty mask, anything from 32 up a full one
   function automatic logic [IP_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
      logic [IP_W-1:0] m;
      if (len >= PLEN_HOST) begin
         m = {IP_W{1'b1}};
      end else begin
         m = ~({IP_W{1'b1}} >> len[4:0]);
      end
      return m;
   endfunction

endpackage

[design/fmatt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmatt_req_if / fmatt_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface fmatt_req_if;
   logic                         valid;
   logic                         ready;
   logic [fmatt_pkg::FUNC_W-1:0] func;
   logic [fmatt_pkg::IP_W-1:0]   client_ip;
   logic [fmatt_pkg::IP_W-1:0]   query_ip;
   logic [fmatt_pkg::PORT_W-1:0] query_port;
   logic [fmatt_pkg::IP_W-1:0]   rule_in_ip;
   logic [fmatt_pkg::PORT_W-1:0] rule_in_port;
   logic [fmatt_pkg::IP_W-1:0]   rule_out_ip;
   logic [fmatt_pkg::PORT_W-1:0] rule_out_port;
   logic [fmatt_pkg::IP_W-1:0]   rule_net_base;
   logic [fmatt_pkg::PLEN_W-1:0] rule_prefix_len;

   modport source (output valid, func, client_ip, query_ip, query_port, rule_in_ip,
                   rule_in_port, rule_out_ip, rule_out_port, rule_net_base,
                   rule_prefix_len, input ready);
   modport sink (input valid, func, client_ip, query_ip, query_port, rule_in_ip,
                 rule_in_port, rule_out_ip, rule_out_port, rule_net_base,
                 rule_prefix_len, output ready);
endinterface

interface fmatt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fmatt_pkg::IP_W-1:0]   result_ip;
   logic [fmatt_pkg::PORT_W-1:0] result_port;
   logic                         matched;
   logic                         table_full;

   modport source (output valid, result_ip, result_port, matched, table_full,
                   input ready);
   modport sink (input valid, result_ip, result_port, matched, table_full,
                 output ready);
endinterface

[design/fmatt_rule_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmatt_rule_mem
// Rule storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmatt_rule_mem #(
   parameter int RULE_SLOTS = fmatt_pkg::RULE_SLOTS_DEF,
   parameter int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  fmatt_pkg::rule_type wr_rule,
   input  logic [IDX_W-1:0]    rd_addr,
   output fmatt_pkg::rule_type rd_rule
);

   fmatt_pkg::rule_type rule_ram_ff [RULE_SLOTS];
   fmatt_pkg::rule_type rd_rule_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_ram_ff[wr_addr] <= wr_rule;
      end
      rd_rule_ff <= rule_ram_ff[rd_addr];
   end

   assign rd_rule = rd_rule_ff;

endmodule

[design/fmatt_scan_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmatt_scan_ctrl
// Rule count, append/clear handling, one-rule-per-cycle lookup scan and
// the response register.
// ----------------------------------------------------------------------------
module fmatt_scan_ctrl #(
   parameter int RULE_SLOTS = fmatt_pkg::RULE_SLOTS_DEF,
   parameter int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
   parameter int CNT_W      = $clog2(RULE_SLOTS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   fmatt_req_if.sink            req_bus,
   fmatt_rsp_if.source          rsp_bus,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_addr,
   output fmatt_pkg::rule_type  mem_wr_rule,
   output logic [IDX_W-1:0]     mem_rd_addr,
   input  fmatt_pkg::rule_type  mem_rd_rule
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [fmatt_pkg::IP_W-1:0]   client_ff, client_in;
   logic [fmatt_pkg::IP_W-1:0]   qip_ff, qip_in;
   logic [fmatt_pkg::PORT_W-1:0] qport_ff, qport_in;
   logic [fmatt_pkg::IP_W-1:0]   pend_ip_ff, pend_ip_in;
   logic [fmatt_pkg::PORT_W-1:0] pend_port_ff, pend_port_in;
   logic                         pend_hit_ff, pend_hit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fmatt_pkg::IP_W-1:0]   rsp_ip_ff, rsp_ip_in;
   logic [fmatt_pkg::PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic                         rsp_full_ff, rsp_full_in;

   logic             accept;
   logic             out_free;
   logic             tbl_full;
   logic             hit;
   logic [CNT_W-1:0] idx_next;
   logic             last;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign tbl_full      = (count_ff == CNT_W'(RULE_SLOTS));

   // the entry under test arrived from the memory this cycle
   assign hit = (mem_rd_rule.match_ip == qip_ff) && (mem_rd_rule.match_port == qport_ff)
                && (((client_ff ^ mem_rd_rule.net_base)
                     & fmatt_pkg::prefix_mask(mem_rd_rule.prefix_len)) == '0);
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign last     = (idx_next >= count_ff);

   // next entry is fetched speculatively while the current one is compared
   assign mem_rd_addr = (state_ff == ST_SCAN) ? IDX_W'(idx_next) : '0;

   assign mem_wr_addr            = IDX_W'(count_ff);
   assign mem_wr_rule.match_ip   = req_bus.rule_in_ip;
   assign mem_wr_rule.match_port = req_bus.rule_in_port;
   assign mem_wr_rule.repl_ip    = req_bus.rule_out_ip;
   assign mem_wr_rule.repl_port  = req_bus.rule_out_port;
   assign mem_wr_rule.net_base   = req_bus.rule_net_base;
   assign mem_wr_rule.prefix_len = req_bus.rule_prefix_len;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      client_in    = client_ff;
      qip_in       = qip_ff;
      qport_in     = qport_ff;
      pend_ip_in   = pend_ip_ff;
      pend_port_in = pend_port_ff;
      pend_hit_in  = pend_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_ip_in    = rsp_ip_ff;
      rsp_port_in  = rsp_port_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_full_in  = rsp_full_ff;
      mem_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_ip_in    = '0;
               rsp_port_in  = '0;
               rsp_hit_in   = 1'b0;
               rsp_full_in  = 1'b0;
               case (req_bus.func)
                  fmatt_pkg::FN_APPEND: begin
                     if (tbl_full) begin
                        rsp_full_in = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  fmatt_pkg::FN_CLEAR: begin
                     count_in = '0;
                  end
                  fmatt_pkg::FN_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_ip_in   = req_bus.query_ip;
                        rsp_port_in = req_bus.query_port;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                        client_in    = req_bus.client_ip;
                        qip_in       = req_bus.query_ip;
                        qport_in     = req_bus.query_port;
                        idx_in       = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               pend_ip_in   = mem_rd_rule.repl_ip;
               pend_port_in = mem_rd_rule.repl_port;
               pend_hit_in  = 1'b1;
               state_in     = ST_WAIT;
            end else if (last) begin
               pend_ip_in   = qip_ff;
               pend_port_in = qport_ff;
               pend_hit_in  = 1'b0;
               state_in     = ST_WAIT;
            end else begin
               idx_in = IDX_W'(idx_next);
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ip_in    = pend_ip_ff;
               rsp_port_in  = pend_port_ff;
               rsp_hit_in   = pend_hit_ff;
               rsp_full_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      client_ff    <= client_in;
      qip_ff       <= qip_in;
      qport_ff     <= qport_in;
      pend_ip_ff   <= pend_ip_in;
      pend_port_ff <= pend_port_in;
      pend_hit_ff  <= pend_hit_in;
      rsp_ip_ff    <= rsp_ip_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_ip   = rsp_ip_ff;
   assign rsp_bus.result_port = rsp_port_ff;
   assign rsp_bus.matched     = rsp_hit_ff;
   assign rsp_bus.table_full  = rsp_full_ff;

endmodule

[design/first_match_address_translation_table.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// first_match_address_translation_table_core
// Ordered first-match translation rule table with append, clear and lookup.
//
//   channel  | dir | content
//   ---------+-----+-------------------------------------------------------
//   req_bus  | in  | func, client/query address and port, rule to append
//   rsp_bus  | out | result address and port, matched, table_full
//
// Append, clear, unused codes and a lookup in an empty table answer in the
// cycle after the transaction. A lookup reads one rule per cycle from the
// rule memory up to the first hit or the last rule, then waits for a free output.
// Reset empties the table at once (rule count only, no memory sweep).
// A stalled response holds; a new request is taken while it is drained.
// ----------------------------------------------------------------------------
module first_match_address_translation_table_core #(
   parameter int RULE_SLOTS = fmatt_pkg::RULE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fmatt_req_if.sink   req_bus,
   fmatt_rsp_if.source rsp_bus
);

   localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CNT_W = $clog2(RULE_SLOTS + 1);

   logic                mem_wr_en;
   logic [IDX_W-1:0]    mem_wr_addr;
   fmatt_pkg::rule_type mem_wr_rule;
   logic [IDX_W-1:0]    mem_rd_addr;
   fmatt_pkg::rule_type mem_rd_rule;

   fmatt_rule_mem #(
      .RULE_SLOTS (RULE_SLOTS),
      .IDX_W      (IDX_W)
   ) u_rule_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_rule (mem_wr_rule),
      .rd_addr (mem_rd_addr),
      .rd_rule (mem_rd_rule)
   );

   fmatt_scan_ctrl #(
      .RULE_SLOTS (RULE_SLOTS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_scan_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_rule (mem_wr_rule),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_rule (mem_rd_rule)
   );

   // rule memory is written only by an accepted append transaction
   `ASSERT_IMPLY(a_wr_on_append, mem_wr_en, req_bus.valid && req_bus.ready && req_bus.func == fmatt_pkg::FN_APPEND, "rule write without append")

   // a request is never taken while an undrained response occupies the output
   `ASSERT_IMPLY(a_no_overrun, req_bus.valid && req_bus.ready, !rsp_bus.valid || rsp_bus.ready, "request accepted over pending response")

   // a dropped append never reports a match
   `ASSERT_ALWAYS(a_full_no_hit, !(rsp_bus.valid && rsp_bus.table_full && rsp_bus.matched), "table_full together with matched")

endmodule
